// File: rtl/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg
// Shared types, character codes and token codes of the expression tokenizer.
// ----------------------------------------------------------------------------
package etok_pkg;

  localparam int DEF_MAX_LINE    = 1024;
  localparam int DEF_NUMBER_BITS = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 10;
  localparam int MAX_TOK = 3;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_Z      = 8'h7a;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_O      = 8'h6f;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [3:0] RADIX     = 4'd10;

  localparam logic [1:0] FN_UNKNOWN = 2'd0;
  localparam logic [1:0] FN_SIN     = 2'd1;
  localparam logic [1:0] FN_COS     = 2'd2;
  localparam logic [1:0] FN_POW     = 2'd3;

  typedef enum logic [2:0] {
    KIND_NUMBER   = 3'd0,
    KIND_OPERATOR = 3'd1,
    KIND_VARIABLE = 3'd2,
    KIND_FUNCTION = 3'd3,
    KIND_BRACKET  = 3'd4,
    KIND_END      = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } tok_t;

  // Tokens caused by one character, in delivery order.
  typedef struct packed {
    tok_t [MAX_TOK-1:0] toks;
    logic [1:0]         cnt;
  } grp_t;

  function automatic tok_t mk_tok(kind_e k, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    tok_t t;
    t.kind  = k;
    t.value = v;
    t.pos   = p;
    return t;
  endfunction

endpackage

// File: rtl/etok_lexer.sv
// ----------------------------------------------------------------------------
// etok_lexer
// Lexer state and the single-pass decode of one character into its tokens.
// ----------------------------------------------------------------------------
module etok_lexer #(
  parameter int MAX_LINE    = etok_pkg::DEF_MAX_LINE,
  parameter int NUMBER_BITS = etok_pkg::DEF_NUMBER_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      char_i,
  input  logic            eol_i,
  output etok_pkg::grp_t  grp_o
);
  import etok_pkg::*;

  localparam int PW = $clog2(MAX_LINE);
  localparam int NB = NUMBER_BITS;
  localparam int PX = (PW > POS_W) ? PW : POS_W;
  localparam int VX = (NB > VALUE_W) ? NB : VALUE_W;

  logic [NB-1:0] acc_q, acc_d;
  logic          innum_q, innum_d;
  logic [1:0]    skip_q, skip_d;
  logic [1:0]    pf_q, pf_d;
  logic [PW-1:0] line_q, line_d;

  logic [PW-1:0]   p_m1, p_m2, p_nx;
  logic [NB+3:0]   prod;
  logic [NB-1:0]   acc_new;
  logic [3:0]      digit;
  logic            is_digit, is_bracket, is_oper, is_lower, is_ignored;
  logic [POS_W-1:0] pos_p, pos_m1, pos_m2;
  logic [VALUE_W-1:0] acc_val, accn_val, chr_val;

  assign p_m1 = (line_q == '0) ? PW'(MAX_LINE - 1) : line_q - PW'(1);
  assign p_m2 = (line_q >= PW'(2)) ? line_q - PW'(2) : line_q + PW'(MAX_LINE - 2);
  assign p_nx = (line_q == PW'(MAX_LINE - 1)) ? '0 : line_q + PW'(1);

  assign pos_p  = POS_W'(PX'(line_q));
  assign pos_m1 = POS_W'(PX'(p_m1));
  assign pos_m2 = POS_W'(PX'(p_m2));

  assign digit    = 4'(char_i - CH_0);
  assign prod     = ((NB+4)'(acc_q) << 3) + ((NB+4)'(acc_q) << 1) + (NB+4)'(digit);
  assign acc_new  = (|prod[NB+3:NB]) ? '1 : prod[NB-1:0];
  assign acc_val  = VALUE_W'(VX'(acc_q));
  assign accn_val = VALUE_W'(VX'(acc_new));
  assign chr_val  = VALUE_W'(char_i);

  assign is_digit   = (char_i >= CH_0) && (char_i <= CH_9);
  assign is_bracket = (char_i == CH_LPAR) || (char_i == CH_RPAR);
  assign is_oper    = (char_i == CH_PLUS) || (char_i == CH_MINUS) ||
                      (char_i == CH_STAR) || (char_i == CH_SLASH);
  assign is_lower   = (char_i >= CH_A) && (char_i <= CH_Z);
  assign is_ignored = (char_i == CH_NUL) || (char_i == CH_CR) || (char_i == CH_LF);

  always_comb begin
    logic [1:0] cnt;
    logic [1:0] pf;
    cnt     = 2'd0;
    pf      = pf_q;
    grp_o   = '0;
    acc_d   = acc_q;
    innum_d = innum_q;
    skip_d  = skip_q;
    pf_d    = pf_q;
    line_d  = p_nx;

    if (skip_q == 2'd2) begin
      if ((pf_q == FN_SIN && char_i != CH_I) || (pf_q == FN_COS && char_i != CH_O)) begin
        pf_d = FN_UNKNOWN;
      end
      skip_d = 2'd1;
      if (eol_i) begin
        grp_o.toks[cnt] = mk_tok(KIND_FUNCTION, VALUE_W'(FN_UNKNOWN), pos_m1);
        cnt = cnt + 2'd1;
      end
    end else if (skip_q == 2'd1) begin
      if ((pf_q == FN_SIN && char_i != CH_N) || (pf_q == FN_COS && char_i != CH_S)) begin
        pf = FN_UNKNOWN;
      end
      grp_o.toks[cnt] = mk_tok(KIND_FUNCTION, VALUE_W'(pf), pos_m2);
      cnt = cnt + 2'd1;
      if (is_bracket) begin
        grp_o.toks[cnt] = mk_tok(KIND_BRACKET, chr_val, pos_p);
        cnt = cnt + 2'd1;
      end
      skip_d = 2'd0;
      pf_d   = FN_UNKNOWN;
    end else if (is_digit) begin
      acc_d   = acc_new;
      innum_d = 1'b1;
      if (eol_i) begin
        grp_o.toks[cnt] = mk_tok(KIND_NUMBER, accn_val, pos_p);
        cnt = cnt + 2'd1;
      end
    end else begin
      if (innum_q) begin
        grp_o.toks[cnt] = mk_tok(KIND_NUMBER, acc_val, pos_m1);
        cnt = cnt + 2'd1;
      end
      acc_d   = '0;
      innum_d = 1'b0;
      priority if (is_oper) begin
        grp_o.toks[cnt] = mk_tok(KIND_OPERATOR, chr_val, pos_p);
        cnt = cnt + 2'd1;
      end else if (char_i == CH_X) begin
        grp_o.toks[cnt] = mk_tok(KIND_VARIABLE, chr_val, pos_p);
        cnt = cnt + 2'd1;
      end else if (char_i == CH_CARET) begin
        grp_o.toks[cnt] = mk_tok(KIND_FUNCTION, VALUE_W'(FN_POW), pos_p);
        cnt = cnt + 2'd1;
      end else if (is_lower) begin
        pf_d   = (char_i == CH_S) ? FN_SIN : ((char_i == CH_C) ? FN_COS : FN_UNKNOWN);
        skip_d = 2'd2;
        if (eol_i) begin
          grp_o.toks[cnt] = mk_tok(KIND_FUNCTION, VALUE_W'(FN_UNKNOWN), pos_p);
          cnt = cnt + 2'd1;
        end
      end else if (is_bracket) begin
        grp_o.toks[cnt] = mk_tok(KIND_BRACKET, chr_val, pos_p);
        cnt = cnt + 2'd1;
      end else if (!is_ignored) begin
        grp_o.toks[cnt] = mk_tok(KIND_ERROR, chr_val, pos_p);
        cnt = cnt + 2'd1;
      end else begin
        cnt = cnt;
      end
    end

    if (eol_i) begin
      grp_o.toks[cnt] = mk_tok(KIND_END, '0, pos_p);
      cnt     = cnt + 2'd1;
      acc_d   = '0;
      innum_d = 1'b0;
      skip_d  = 2'd0;
      pf_d    = FN_UNKNOWN;
      line_d  = '0;
    end
    grp_o.cnt = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      innum_q <= 1'b0;
      skip_q  <= 2'd0;
      pf_q    <= FN_UNKNOWN;
      line_q  <= '0;
    end else if (fire_i) begin
      acc_q   <= acc_d;
      innum_q <= innum_d;
      skip_q  <= skip_d;
      pf_q    <= pf_d;
      line_q  <= line_d;
    end
  end

endmodule

// File: rtl/etok_obuf.sv
// ----------------------------------------------------------------------------
// etok_obuf
// Result register: holds the tokens of one character and sends them one beat
// at a time.
// ----------------------------------------------------------------------------
module etok_obuf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  etok_pkg::grp_t               grp_i,
  output logic                         can_load_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   token_kind_o,
  output logic [etok_pkg::VALUE_W-1:0] token_value_o,
  output logic [etok_pkg::POS_W-1:0]   char_position_o,
  output logic                         last_result_o
);
  import etok_pkg::*;

  logic       busy_q, busy_d;
  logic [1:0] head_q, head_d;
  grp_t       grp_q;
  tok_t       cur;
  logic       take, last;

  assign cur  = grp_q.toks[head_q];
  assign last = (head_q == grp_q.cnt - 2'd1);
  assign take = busy_q && !out_stall_i;

  assign can_load_o      = !busy_q || (take && last);
  assign out_valid_o     = busy_q;
  assign token_kind_o    = cur.kind;
  assign token_value_o   = cur.value;
  assign char_position_o = cur.pos;
  assign last_result_o   = last;

  always_comb begin
    busy_d = busy_q;
    head_d = head_q;
    if (take) begin
      head_d = head_q + 2'd1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i && can_load_o) begin
      busy_d = 1'b1;
      head_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      head_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      grp_q <= grp_i;
    end
  end

  a_busy_has_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (grp_q.cnt != 2'd0) && (head_q < grp_q.cnt))
    else $error("result register holds no token at its head");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=> out_valid_o && (head_q == $past(head_q) + 2'd1))
    else $error("remaining tokens of a group were dropped");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_stall_i) |=> busy_q && $stable(head_q))
    else $error("stalled beat moved");

endmodule

// File: rtl/expression_tokenizer.sv
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming tokenizer for a space-free arithmetic expression line.
//
// Input channel: one character per beat (char_code_i, end_of_line_i), with
// in_valid_i / in_stall_o. Output channel: one token per beat (token_kind_o,
// token_value_o, char_position_o, last_result_o) with out_valid_o /
// out_stall_i. A character yields zero to three tokens; last_result_o marks
// the final token of a character.
// A character accepted into the input register is decoded combinationally and
// loaded into the result register, from which its first token is offered.
// Throughput: one character per cycle while each gives at most one token and
// out_stall_i is low; a character with several tokens holds the result register
// until its last token is taken through the single token port.
// Reset clears the number accumulator, function name tracking and line
// position. While out_stall_i is high the current token holds, one more
// character waits in the input register, and in_stall_o rises.
// ----------------------------------------------------------------------------
module expression_tokenizer #(
  parameter int MAX_LINE    = etok_pkg::DEF_MAX_LINE,
  parameter int NUMBER_BITS = etok_pkg::DEF_NUMBER_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   char_code_i,
  input  logic                         end_of_line_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   token_kind_o,
  output logic [etok_pkg::VALUE_W-1:0] token_value_o,
  output logic [etok_pkg::POS_W-1:0]   char_position_o,
  output logic                         last_result_o
);
  import etok_pkg::*;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eol_q;
  logic       can_load, advance, in_take;
  grp_t       grp;

  assign advance    = in_valid_q && can_load;
  assign in_stall_o = in_valid_q && !can_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      eol_q  <= end_of_line_i;
    end
  end

  etok_lexer #(
    .MAX_LINE   (MAX_LINE),
    .NUMBER_BITS(NUMBER_BITS)
  ) u_lexer (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(advance),
    .char_i(char_q),
    .eol_i (eol_q),
    .grp_o (grp)
  );

  etok_obuf u_obuf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && (grp.cnt != 2'd0)),
    .grp_i          (grp),
    .can_load_o     (can_load),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_value_o  (token_value_o),
    .char_position_o(char_position_o),
    .last_result_o  (last_result_o)
  );

endmodule

// File: test/expression_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer_tb
// Self-checking bench for the streaming expression tokenizer. A short table
// of characters covers every token kind, both recognized functions, names
// cut by end of line, brackets in the third name slot, ignored bytes and
// syntax errors. Random lines of well-formed pieces and noise follow. A
// local tokenizer predicts every token. Random idle and stall bursts hit
// both channels.
// ----------------------------------------------------------------------------
module expression_tokenizer_tb;
  import etok_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eol;
    logic        typed;
    kind_e       kind;
    logic [31:0] value;
    logic [9:0]  pos;
  } char_beat_s;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [9:0]  pos;
    logic        last;
  } token_s;

  // typed rows carry the first token their character must produce
  localparam char_beat_s SCRIPT [0:24] = '{
    '{CH_0,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_9,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_PLUS,  1'b0, 1'b1, KIND_NUMBER,   32'd9,             10'd1},
    '{CH_X,     1'b0, 1'b1, KIND_VARIABLE, 32'(CH_X),         10'd3},
    '{CH_MINUS, 1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_CARET, 1'b0, 1'b1, KIND_FUNCTION, 32'(FN_POW),       10'd5},
    '{CH_STAR,  1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_S,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_I,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_N,     1'b0, 1'b1, KIND_FUNCTION, 32'(FN_SIN),       10'd7},
    '{CH_C,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_O,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_S,     1'b0, 1'b1, KIND_FUNCTION, 32'(FN_COS),       10'd10},
    '{CH_Z,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{"A",      1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_RPAR,  1'b0, 1'b1, KIND_FUNCTION, 32'(FN_UNKNOWN),   10'd13},
    '{CH_SLASH, 1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_NUL,   1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_LPAR,  1'b0, 1'b1, KIND_BRACKET,  32'(CH_LPAR),      10'd18},
    '{8'hff,    1'b0, 1'b1, KIND_ERROR,    32'h0000_00ff,     10'd19},
    '{CH_CR,    1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_LF,    1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{"q",      1'b1, 1'b1, KIND_FUNCTION, 32'(FN_UNKNOWN),   10'd22},
    '{CH_C,     1'b0, 1'b0, KIND_NUMBER,   32'd0,             10'd0},
    '{CH_O,     1'b1, 1'b1, KIND_FUNCTION, 32'(FN_UNKNOWN),   10'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          char_code_i;
  logic                end_of_line_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          token_kind_o;
  logic [VALUE_W-1:0]  token_value_o;
  logic [POS_W-1:0]    char_position_o;
  logic                last_result_o;

  char_beat_s char_stream[$];
  token_s     char_tokens[$];
  token_s     pending_tokens[$];
  int         taken = 0;
  int         mismatches = 0;
  bit         calm = 1'b0;

  // tokenizer state
  logic [31:0] num_acc;
  logic        in_num;
  logic [1:0]  name_left;
  logic [1:0]  fn_guess;
  logic [9:0]  col;

  expression_tokenizer DUT (.*);

  always #5 clk_i = ~clk_i;

  function automatic void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic void emit(kind_e k, logic [31:0] v, logic [9:0] p);
    char_tokens.push_back('{kind: k, value: v, pos: p, last: 1'b0});
  endfunction

  function automatic void clear_lexer();
    num_acc   = '0;
    in_num    = 1'b0;
    name_left = 2'd0;
    fn_guess  = FN_UNKNOWN;
    col       = '0;
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic eol);
    logic [9:0]      p;
    longint unsigned d;
    p = col;
    char_tokens.delete();
    if (name_left == 2'd2) begin
      if ((fn_guess == FN_SIN && c != CH_I) || (fn_guess == FN_COS && c != CH_O))
        fn_guess = FN_UNKNOWN;
      name_left = 2'd1;
      if (eol) begin
        emit(KIND_FUNCTION, 32'(FN_UNKNOWN), p - 10'd1);
        name_left = 2'd0;
      end
    end else if (name_left == 2'd1) begin
      if ((fn_guess == FN_SIN && c != CH_N) || (fn_guess == FN_COS && c != CH_S))
        fn_guess = FN_UNKNOWN;
      emit(KIND_FUNCTION, 32'(fn_guess), p - 10'd2);
      if (c == CH_LPAR || c == CH_RPAR) emit(KIND_BRACKET, 32'(c), p);
      name_left = 2'd0;
      fn_guess  = FN_UNKNOWN;
    end else if (c >= CH_0 && c <= CH_9) begin
      d = 64'(c - CH_0);
      if (64'(num_acc) > (64'h0000_0000_ffff_ffff - d) / 64'(RADIX)) num_acc = '1;
      else num_acc = 32'(64'(num_acc) * 64'(RADIX) + d);
      in_num = 1'b1;
      if (eol) emit(KIND_NUMBER, num_acc, p);
    end else begin
      if (in_num) emit(KIND_NUMBER, num_acc, p - 10'd1);
      num_acc = '0;
      in_num  = 1'b0;
      if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
        emit(KIND_OPERATOR, 32'(c), p);
      end else if (c == CH_X) begin
        emit(KIND_VARIABLE, 32'(c), p);
      end else if (c == CH_CARET) begin
        emit(KIND_FUNCTION, 32'(FN_POW), p);
      end else if (c >= CH_A && c <= CH_Z) begin
        fn_guess  = (c == CH_S) ? FN_SIN : ((c == CH_C) ? FN_COS : FN_UNKNOWN);
        name_left = 2'd2;
        if (eol) begin
          emit(KIND_FUNCTION, 32'(FN_UNKNOWN), p);
          name_left = 2'd0;
        end
      end else if (c == CH_LPAR || c == CH_RPAR) begin
        emit(KIND_BRACKET, 32'(c), p);
      end else if (c != CH_NUL && c != CH_CR && c != CH_LF) begin
        emit(KIND_ERROR, 32'(c), p);
      end
    end
    if (eol) begin
      emit(KIND_END, 32'd0, p);
      clear_lexer();
    end else begin
      col = p + 10'd1;
    end
    if (char_tokens.size() > 0) char_tokens[$].last = 1'b1;
  endfunction

  function automatic void push_char(logic [7:0] c);
    char_stream.push_back('{c, 1'b0, 1'b0, KIND_NUMBER, 32'd0, 10'd0});
  endfunction

  function automatic void build_line(int min_chars);
    int first;
    int len;
    bit done;
    first = char_stream.size();
    do begin
      done = 1'b0;
      case ($urandom_range(0, 9))
        0, 1: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
          repeat (len) push_char(CH_0 + 8'($urandom_range(0, 9)));
        end
        2: begin
          case ($urandom_range(0, 3))
            0: push_char(CH_PLUS);
            1: push_char(CH_MINUS);
            2: push_char(CH_STAR);
            default: push_char(CH_SLASH);
          endcase
        end
        3: push_char(($urandom_range(0, 1) == 0) ? CH_X : CH_CARET);
        4: push_char(($urandom_range(0, 1) == 0) ? CH_LPAR : CH_RPAR);
        5, 6: begin
          case ($urandom_range(0, 2))
            0: begin push_char(CH_S); push_char(CH_I); push_char(CH_N); end
            1: begin push_char(CH_C); push_char(CH_O); push_char(CH_S); end
            default: begin
              push_char(8'($urandom_range(CH_A, CH_Z)));
              push_char(8'($urandom_range(0, 255)));
              if ($urandom_range(0, 2) == 0)
                push_char(($urandom_range(0, 1) == 0) ? CH_LPAR : CH_RPAR);
              else
                push_char(8'($urandom_range(0, 255)));
            end
          endcase
        end
        7: begin
          // open a name and let the line end inside it
          push_char(($urandom_range(0, 1) == 0) ? CH_S : 8'($urandom_range(CH_A, CH_Z)));
          if ($urandom_range(0, 1) == 0) push_char(8'($urandom_range(0, 255)));
          done = 1'b1;
        end
        8: push_char(8'($urandom_range(0, 255)));
        default: begin
          case ($urandom_range(0, 3))
            0: push_char(CH_NUL);
            1: push_char(CH_CR);
            2: push_char(CH_LF);
            default: push_char(8'($urandom_range(0, 255)));
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0) done = 1'b1;
    end while (char_stream.size() - first < min_chars || !done);
    char_stream[$].eol = 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    token_s want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_tokens.size() == 0) begin
          flag($sformatf("unexpected token kind %0d value %h pos %0d last %0b",
                         token_kind_o, token_value_o, char_position_o, last_result_o));
        end else begin
          want = pending_tokens.pop_front();
          if (token_kind_o !== want.kind || token_value_o !== want.value ||
              char_position_o !== want.pos || last_result_o !== want.last)
            flag($sformatf("got kind %0d value %h pos %0d last %0b, want %0d %h %0d %0b",
                           token_kind_o, token_value_o, char_position_o, last_result_o,
                           want.kind, want.value, want.pos, want.last));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        tokenize_char(char_code_i, end_of_line_i);
        if (char_stream[taken].typed) begin
          char_tokens[0].kind  = char_stream[taken].kind;
          char_tokens[0].value = char_stream[taken].value;
          char_tokens[0].pos   = char_stream[taken].pos;
        end
        foreach (char_tokens[i]) pending_tokens.push_back(char_tokens[i]);
        taken++;
      end
    end
  end

  initial begin : stall_gen
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 31) == 0) begin
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  initial begin : limit
    #2_000_000;
    $display("expression_tokenizer_tb: errors");
    $finish;
  end

  initial begin : driver
    int base;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = '0;
    end_of_line_i = 1'b0;
    clear_lexer();
    foreach (SCRIPT[i]) char_stream.push_back(SCRIPT[i]);
    while (char_stream.size() < 90) build_line(1);
    base = char_stream.size();
    while (char_stream.size() < base + 40) build_line(1);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < char_stream.size(); i++) begin
      calm = (i >= char_stream.size() - 40);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
      in_valid_i    <= 1'b1;
      char_code_i   <= char_stream[i].ch;
      end_of_line_i <= char_stream[i].eol;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("expression_tokenizer_tb: clean");
    else $display("expression_tokenizer_tb: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/etok_pkg.sv
rtl/etok_lexer.sv
rtl/etok_obuf.sv
rtl/expression_tokenizer.sv
test/expression_tokenizer_tb.sv
